[rtl/gdr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_pkg: shared types and constants of the grid DDA ray caster
// Operation codes, controller/datapath command and status, register indexes.
// ----------------------------------------------------------------------------
package gdr_pkg;

  localparam int CFG_DW  = 24;   // widest configuration register
  localparam int DIV_W   = 64;   // divider dividend / quotient width
  localparam int DIVS_W  = 32;   // divider divisor / remainder width
  localparam int ROOT_W  = 32;   // square root result width
  localparam int CELL_W  = 19;   // signed cell coordinate during the walk
  localparam int LEN_W   = 50;   // running ray length, Q.16
  localparam int PROD_W  = 51;   // shared multiplier product
  localparam int MUL_AW  = 33;   // multiplier operand a (signed)
  localparam int MUL_BW  = 18;   // multiplier operand b (signed)

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MAP_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_MAP_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_CELL_SIZE  = 2'd2;
  localparam cfg_idx_t CFG_MAX_RAY    = 2'd3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CAST = 1'b1;

  localparam logic SIDE_X = 1'b0;
  localparam logic SIDE_Y = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_DIV_PX,
    OP_DIV_PY,
    OP_DIV_SX,
    OP_SQRT_X,
    OP_MUL_LX,
    OP_MUL_IX,
    OP_DIV_SY,
    OP_SQRT_Y,
    OP_MUL_LY,
    OP_MUL_IY,
    OP_MUL_HX,
    OP_MUL_HY,
    OP_STEP,
    OP_READ,
    OP_CHECK,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic go;       // start the unit that op names
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;       // arithmetic unit result ready
    logic can_x;
    logic can_y;
    logic walk_more;  // no wall seen, limit not reached, some axis steps
  } status_t;

endpackage : gdr_pkg
`default_nettype wire

[rtl/gdr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_if: valid/ready channels of the grid DDA ray caster
// Input items (map write or cast) and result items.
// ----------------------------------------------------------------------------
interface gdr_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [11:0]        cell_index;
  logic               wall;
  logic [23:0]        pos_x;
  logic [23:0]        pos_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;

  modport source (output valid, kind, cell_index, wall, pos_x, pos_y, dir_x, dir_y,
                  input ready);
  modport sink (input valid, kind, cell_index, wall, pos_x, pos_y, dir_x, dir_y,
                output ready);
endinterface : gdr_in_if

interface gdr_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               hit_side;
  logic [23:0]        ray_distance;
  logic signed [24:0] hit_x;
  logic signed [24:0] hit_y;

  modport source (output valid, hit, hit_side, ray_distance, hit_x, hit_y,
                  input ready);
  modport sink (input valid, hit, hit_side, ray_distance, hit_x, hit_y,
                output ready);
endinterface : gdr_out_if
`default_nettype wire

[rtl/gdr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_div: restoring divider, one quotient bit per cycle
// Quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module gdr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [gdr_pkg::DIV_W-1:0]  dividend,
  input  logic [gdr_pkg::DIVS_W-1:0] divisor,
  output logic                       done,
  output logic [gdr_pkg::DIV_W-1:0]  quot,
  output logic [gdr_pkg::DIVS_W-1:0] rem
);
  import gdr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [DIVS_W-1:0] r_r, r_nxt;
  logic [DIVS_W-1:0] d_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVS_W:0]   r_sh;
  logic [DIVS_W:0]   r_sub;

  always_comb begin
    r_sh  = {r_r, q_r[DIV_W-1]};
    r_sub = r_sh - {1'b0, d_r};
    if (r_sh >= {1'b0, d_r}) begin
      r_nxt = r_sub[DIVS_W-1:0];
      q_nxt = {q_r[DIV_W-2:0], 1'b1};
    end else begin
      r_nxt = r_sh[DIVS_W-1:0];
      q_nxt = {q_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule : gdr_div
`default_nettype wire

[rtl/gdr_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_sqrt: integer square root, one result bit per cycle
// Floor of the root of a 64-bit value; 32 iterations.
// ----------------------------------------------------------------------------
module gdr_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [gdr_pkg::DIV_W-1:0]  value,
  output logic                       done,
  output logic [gdr_pkg::ROOT_W-1:0] root
);
  import gdr_pkg::*;

  logic [DIV_W-1:0] v_r, r_r, b_r;
  logic [DIV_W-1:0] rb;
  logic             busy_r;
  logic             done_r;

  assign rb = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && b_r == DIV_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      v_r <= value;
      r_r <= '0;
      b_r <= {2'b01, {(DIV_W-2){1'b0}}};
    end else if (busy_r) begin
      if (v_r >= rb) begin
        v_r <= v_r - rb;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];

endmodule : gdr_sqrt
`default_nettype wire

[rtl/gdr_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_dp: datapath of the grid DDA ray caster
// Wall map, configuration registers, divider, root unit, shared multiplier,
// running ray lengths and the result registers.
// ----------------------------------------------------------------------------
module gdr_dp #(
  parameter int MAX_MAP_SIDE = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gdr_pkg::cmd_t                 cmd,
  output gdr_pkg::status_t              status,
  input  logic                          in_kind,
  input  logic [11:0]                   in_cell_index,
  input  logic                          in_wall,
  input  logic [23:0]                   in_pos_x,
  input  logic [23:0]                   in_pos_y,
  input  logic signed [15:0]            in_dir_x,
  input  logic signed [15:0]            in_dir_y,
  input  logic                          cfg_we,
  input  gdr_pkg::cfg_idx_t             cfg_index,
  input  logic [gdr_pkg::CFG_DW-1:0]    cfg_data,
  output logic                          out_hit,
  output logic                          out_hit_side,
  output logic [23:0]                   out_ray_distance,
  output logic signed [24:0]            out_hit_x,
  output logic signed [24:0]            out_hit_y
);
  import gdr_pkg::*;

  localparam int CELLS = MAX_MAP_SIDE * MAX_MAP_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int SB    = $clog2(MAX_MAP_SIDE);
  localparam int WB    = $clog2(MAX_MAP_SIDE + 1);

  localparam logic signed [37:0] SAT_MAX = 38'sd16777215;
  localparam logic signed [37:0] SAT_MIN = -38'sd16777216;

  // configuration
  logic [6:0]  map_width_r, map_height_r;
  logic [7:0]  cell_size_r;
  logic [23:0] max_ray_r;

  // item registers
  logic [23:0]        px_r, py_r;
  logic signed [15:0] dirx_r, diry_r;
  logic [30:0]        dx2_r, dy2_r;

  // walk state
  logic signed [CELL_W-1:0] cx_r, cy_r;
  logic [15:0]              remx_r, remy_r;
  logic [ROOT_W-1:0]        sx_r, sy_r;
  logic [LEN_W-1:0]         lx_r, ly_r, total_r;
  logic [47:0]              incx_r, incy_r;
  logic                     side_r;
  logic                     hit_r;
  logic                     inmap_r;
  logic                     rd_data_r;
  logic signed [24:0]       hitx_r;

  logic wall_map [CELLS];

  // derived
  logic [WB-1:0]   w, h;
  logic [7:0]      cs;
  logic [15:0]     cq8;
  logic [15:0]     offx, offy;
  logic [31:0]     len2;
  logic [39:0]     limit;
  logic [23:0]     ray_dist;
  logic            can_x, can_y;
  logic            choose_x;
  logic            in_map;
  logic [AW-1:0]   rd_addr, wr_addr, cy_a, w_a;
  logic            wall_now;

  // units
  logic                     div_go, sqrt_go, mul_go;
  logic [DIV_W-1:0]         div_dividend;
  logic [DIVS_W-1:0]        div_divisor;
  logic                     div_done, sqrt_done;
  logic [DIV_W-1:0]         div_quot;
  logic [DIVS_W-1:0]        div_rem;
  logic [ROOT_W-1:0]        sqrt_root;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic                     pend_r;

  function automatic logic [WB-1:0] clamp_side(input logic [6:0] v);
    if (v == 7'd0) begin
      return WB'(1);
    end else if (32'(v) > 32'(MAX_MAP_SIDE)) begin
      return WB'(MAX_MAP_SIDE);
    end else begin
      return WB'(v);
    end
  endfunction

  // pos + floor(dir * dist / 2^14), saturated to 25-bit signed
  function automatic logic signed [24:0] isect(input logic [23:0] pos,
                                               input logic signed [PROD_W-1:0] p);
    logic signed [36:0] q;
    logic signed [37:0] s;
    q = signed'(p[PROD_W-1:14]);
    s = signed'({14'b0, pos}) + 38'(q);
    if (s > SAT_MAX) begin
      return 25'h0FFFFFF;
    end else if (s < SAT_MIN) begin
      return 25'h1000000;
    end else begin
      return s[24:0];
    end
  endfunction

  always_comb begin
    w        = clamp_side(map_width_r);
    h        = clamp_side(map_height_r);
    cs       = (cell_size_r == 8'd0) ? 8'd1 : cell_size_r;
    cq8      = {cs, 8'h00};
    offx     = dirx_r[15] ? remx_r : cq8 - remx_r;
    offy     = diry_r[15] ? remy_r : cq8 - remy_r;
    len2     = {1'b0, dx2_r} + {1'b0, dy2_r};
    limit    = {max_ray_r, 16'h0000};
    ray_dist = (|total_r[LEN_W-1:40]) ? 24'hFFFFFF : total_r[39:16];
    can_x    = dirx_r != 16'sd0;
    can_y    = diry_r != 16'sd0;
    choose_x = can_x && (!can_y || lx_r < ly_r);
    in_map   = !cx_r[CELL_W-1] && !cy_r[CELL_W-1] &&
               ($unsigned(cx_r) < CELL_W'(w)) && ($unsigned(cy_r) < CELL_W'(h));
    cy_a     = AW'(cy_r[SB-1:0]);
    w_a      = AW'(w);
    rd_addr  = cy_a * w_a + AW'(cx_r[SB-1:0]);
    wr_addr  = AW'(in_cell_index);
    wall_now = inmap_r & rd_data_r;
  end

  assign status.done      = div_done | sqrt_done | pend_r;
  assign status.can_x     = can_x;
  assign status.can_y     = can_y;
  assign status.walk_more = !wall_now && (total_r < LEN_W'(limit)) && (can_x || can_y);

  // unit operand selection
  always_comb begin
    div_go  = 1'b0;
    sqrt_go = 1'b0;
    mul_go  = 1'b0;
    if (cmd.go) begin
      div_go  = cmd.op inside {OP_DIV_PX, OP_DIV_PY, OP_DIV_SX, OP_DIV_SY};
      sqrt_go = cmd.op inside {OP_SQRT_X, OP_SQRT_Y};
      mul_go  = cmd.op inside {OP_MUL_LX, OP_MUL_IX, OP_MUL_LY, OP_MUL_IY,
                               OP_MUL_HX, OP_MUL_HY};
    end
  end

  always_comb begin
    case (cmd.op)
      OP_DIV_PX: begin
        div_dividend = DIV_W'(px_r);
        div_divisor  = DIVS_W'(cq8);
      end
      OP_DIV_PY: begin
        div_dividend = DIV_W'(py_r);
        div_divisor  = DIVS_W'(cq8);
      end
      OP_DIV_SX: begin
        div_dividend = {len2, 32'h0};
        div_divisor  = DIVS_W'(dx2_r);
      end
      OP_DIV_SY: begin
        div_dividend = {len2, 32'h0};
        div_divisor  = DIVS_W'(dy2_r);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_MUL_LX: begin
        mul_a = signed'({1'b0, sx_r});
        mul_b = signed'({2'b00, offx});
      end
      OP_MUL_IX: begin
        mul_a = signed'({1'b0, sx_r});
        mul_b = signed'({2'b00, cq8});
      end
      OP_MUL_LY: begin
        mul_a = signed'({1'b0, sy_r});
        mul_b = signed'({2'b00, offy});
      end
      OP_MUL_IY: begin
        mul_a = signed'({1'b0, sy_r});
        mul_b = signed'({2'b00, cq8});
      end
      OP_MUL_HX: begin
        mul_a = signed'({9'b0, ray_dist});
        mul_b = MUL_BW'(dirx_r);
      end
      OP_MUL_HY: begin
        mul_a = signed'({9'b0, ray_dist});
        mul_b = MUL_BW'(diry_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // root operand is the quotient just produced
  gdr_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sqrt_go),
    .value (div_quot),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 7'd64;
      map_height_r <= 7'd64;
      cell_size_r  <= 8'd64;
      max_ray_r    <= 24'hFFFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width_r  <= cfg_data[6:0];
        CFG_MAP_HEIGHT: map_height_r <= cfg_data[6:0];
        CFG_CELL_SIZE:  cell_size_r  <= cfg_data[7:0];
        CFG_MAX_RAY:    max_ray_r    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // wall map: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && in_kind == KIND_LOAD && 32'(in_cell_index) < 32'(CELLS)) begin
      wall_map[wr_addr] <= in_wall;
    end
    rd_data_r <= wall_map[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_go) begin
      prod_r <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_kind == KIND_CAST) begin
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      dirx_r  <= in_dir_x;
      diry_r  <= in_dir_y;
      dx2_r   <= 31'(in_dir_x * in_dir_x);
      dy2_r   <= 31'(in_dir_y * in_dir_y);
      total_r <= '0;
      side_r  <= SIDE_X;
      hit_r   <= 1'b0;
      inmap_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_DIV_PX: if (status.done) begin
          cx_r   <= signed'(CELL_W'(div_quot[15:0]));
          remx_r <= div_rem[15:0];
        end
        OP_DIV_PY: if (status.done) begin
          cy_r   <= signed'(CELL_W'(div_quot[15:0]));
          remy_r <= div_rem[15:0];
        end
        OP_SQRT_X: if (status.done) sx_r <= sqrt_root;
        OP_SQRT_Y: if (status.done) sy_r <= sqrt_root;
        OP_MUL_LX: if (status.done) lx_r <= prod_r[LEN_W-1:0];
        OP_MUL_IX: if (status.done) incx_r <= prod_r[47:0];
        OP_MUL_LY: if (status.done) ly_r <= prod_r[LEN_W-1:0];
        OP_MUL_IY: if (status.done) incy_r <= prod_r[47:0];
        OP_MUL_HX: if (status.done) hitx_r <= isect(px_r, prod_r);
        OP_STEP: begin
          if (choose_x) begin
            cx_r    <= dirx_r[15] ? cx_r - 1'b1 : cx_r + 1'b1;
            total_r <= lx_r;
            lx_r    <= lx_r + LEN_W'(incx_r);
            side_r  <= SIDE_X;
          end else begin
            cy_r    <= diry_r[15] ? cy_r - 1'b1 : cy_r + 1'b1;
            total_r <= ly_r;
            ly_r    <= ly_r + LEN_W'(incy_r);
            side_r  <= SIDE_Y;
          end
        end
        OP_READ:  inmap_r <= in_map;
        OP_CHECK: hit_r <= wall_now;
        default: ;
      endcase
    end
  end

  // result registers; y intersection taken straight from the product
  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_hit          <= hit_r;
      out_hit_side     <= side_r;
      out_ray_distance <= ray_dist;
      out_hit_x        <= hitx_r;
      out_hit_y        <= isect(py_r, prod_r);
    end
  end

endmodule : gdr_dp
`default_nettype wire

[rtl/gdr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_ctrl: controller of the grid DDA ray caster
// Sequences setup divisions, roots and products, the cell walk and the
// result transfer.
// ----------------------------------------------------------------------------
module gdr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_kind,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output gdr_pkg::cmd_t    cmd,
  input  gdr_pkg::status_t status
);
  import gdr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_STEP,
    S_READ,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t state_r;
  op_t    op_r;
  logic   out_valid_r;
  logic   out_free;
  op_t    op_after;

  function automatic op_t next_op(input op_t op, input logic cx, input logic cy);
    case (op)
      OP_DIV_PX: return OP_DIV_PY;
      OP_DIV_PY: return cx ? OP_DIV_SX : (cy ? OP_DIV_SY : OP_STEP);
      OP_DIV_SX: return OP_SQRT_X;
      OP_SQRT_X: return OP_MUL_LX;
      OP_MUL_LX: return OP_MUL_IX;
      OP_MUL_IX: return cy ? OP_DIV_SY : OP_STEP;
      OP_DIV_SY: return OP_SQRT_Y;
      OP_SQRT_Y: return OP_MUL_LY;
      OP_MUL_LY: return OP_MUL_IY;
      OP_MUL_IY: return OP_STEP;
      OP_MUL_HX: return OP_MUL_HY;
      OP_MUL_HY: return OP_OUT;
      default:   return OP_NONE;
    endcase
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign op_after  = next_op(op_r, status.can_x, status.can_y);
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.accept = in_valid && state_r == S_IDLE;
    cmd.go     = state_r == S_START;
    case (state_r)
      S_START, S_WAIT: cmd.op = op_r;
      S_STEP:          cmd.op = OP_STEP;
      S_READ:          cmd.op = OP_READ;
      S_CHECK:         cmd.op = OP_CHECK;
      S_EMIT:          cmd.op = out_free ? OP_OUT : OP_NONE;
      default:         cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_kind == KIND_CAST) begin
            op_r    <= OP_DIV_PX;
            state_r <= S_START;
          end
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: begin
          if (status.done) begin
            if (op_after == OP_OUT) begin
              state_r <= S_EMIT;
            end else if (op_after == OP_STEP) begin
              if (status.walk_more) begin
                state_r <= S_STEP;
              end else begin
                op_r    <= OP_MUL_HX;
                state_r <= S_START;
              end
            end else begin
              op_r    <= op_after;
              state_r <= S_START;
            end
          end
        end
        S_STEP: state_r <= S_READ;
        S_READ: state_r <= S_CHECK;
        S_CHECK: begin
          // continue on an empty cell below the limit, else finish
          if (status.walk_more) begin
            state_r <= S_STEP;
          end else begin
            op_r    <= OP_MUL_HX;
            state_r <= S_START;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule : gdr_ctrl
`default_nettype wire

[rtl/grid_dda_ray_cast.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_dda_ray_cast: one-bit wall map with a DDA grid ray caster
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid/ready        kind, cell_index, wall, pos, dir
//   out_ch    source     valid/ready        hit, hit_side, ray_distance, hit_x/y
//   cfg_*     sink       cfg_we, no ready   cfg_index, cfg_data
//
// Map write: stored at its transfer. Cast: a transfer, the two cell divisions, then
// for each nonzero direction component a divide, a root and two products, then per
// cell visited a step, a registered map read and a check, and last the two
// intersection products and the result register; the divider is bit-serial.
// Reset is synchronous; the wall map is not cleared. One waiting result does not
// block input; a second finished result holds until the first one transfers.
// ----------------------------------------------------------------------------
module grid_dda_ray_cast #(
  parameter int MAX_MAP_SIDE = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gdr_in_if.sink                     in_ch,
  gdr_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  gdr_pkg::cfg_idx_t          cfg_index,
  input  logic [gdr_pkg::CFG_DW-1:0] cfg_data
);
  import gdr_pkg::*;

  cmd_t    cmd;
  status_t status;

  gdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  gdr_dp #(
    .MAX_MAP_SIDE (MAX_MAP_SIDE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_kind          (in_ch.kind),
    .in_cell_index    (in_ch.cell_index),
    .in_wall          (in_ch.wall),
    .in_pos_x         (in_ch.pos_x),
    .in_pos_y         (in_ch.pos_y),
    .in_dir_x         (in_ch.dir_x),
    .in_dir_y         (in_ch.dir_y),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_hit          (out_ch.hit),
    .out_hit_side     (out_ch.hit_side),
    .out_ray_distance (out_ch.ray_distance),
    .out_hit_x        (out_ch.hit_x),
    .out_hit_y        (out_ch.hit_y)
  );

endmodule : grid_dda_ray_cast
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: grid DDA ray caster testbench
// Loads wall maps, casts rays and checks every result against an in-bench
// predictor of the walk. Runs several register settings with random idling
// on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import gdr_pkg::*;

  localparam int  SIDE_MAX    = 64;
  localparam int  END_WAIT    = 300;
  localparam int  CYCLE_LIMIT = 3000000;

  typedef struct {
    logic               kind;
    logic [11:0]        cell_index;
    logic               wall;
    logic [23:0]        pos_x;
    logic [23:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } ray_req_t;

  typedef struct {
    logic               hit;
    logic               hit_side;
    logic [23:0]        ray_distance;
    logic signed [24:0] hit_x;
    logic signed [24:0] hit_y;
  } ray_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_MAP_WIDTH;
  logic [CFG_DW-1:0] cfg_data = '0;

  gdr_in_if  in_ch ();
  gdr_out_if out_ch ();

  grid_dda_ray_cast u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  bit          wall_bits [4096];
  logic [6:0]  cur_width = 7'd64;
  logic [6:0]  cur_height = 7'd64;
  logic [7:0]  cur_cell = 8'd64;
  logic [23:0] cur_limit = 24'hFFFFFF;

  ray_req_t pending_q[$];
  ray_res_t cast_q[$];
  int errors = 0;
  int n_casts = 0;
  int n_hits = 0;
  int n_loads = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit long_hold = 1'b0;
  bit took = 1'b0;
  int cycles = 0;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [24:0] ray_point(logic [23:0] pos, longint dir,
                                                   longint ray_dist);
    longint p, q, r;
    p = dir * ray_dist;
    q = (p >= 0) ? (p >>> 14) : -((-p + 16383) >>> 14);
    r = longint'(pos) + q;
    if (r > 16777215) r = 16777215;
    if (r < -16777216) r = -16777216;
    return r[24:0];
  endfunction

  function automatic ray_res_t trace_ray(ray_req_t t);
    ray_res_t res;
    longint unsigned w, h, cq, px, py, dx2, dy2, len2, sx, sy, lx, ly, total, ray_dist;
    longint unsigned base, lim;
    longint dx, dy, cx, cy;
    bit can_x, can_y, hit;
    logic side;
    w = (cur_width == 0) ? 1 : (cur_width > SIDE_MAX ? SIDE_MAX : cur_width);
    h = (cur_height == 0) ? 1 : (cur_height > SIDE_MAX ? SIDE_MAX : cur_height);
    cq = ((cur_cell == 0) ? 1 : cur_cell) << 8;
    px = t.pos_x;
    py = t.pos_y;
    dx = t.dir_x;
    dy = t.dir_y;
    dx2 = dx * dx;
    dy2 = dy * dy;
    len2 = dx2 + dy2;
    can_x = dx != 0;
    can_y = dy != 0;
    cx = px / cq;
    cy = py / cq;
    sx = 0; sy = 0; lx = 0; ly = 0; total = 0;
    hit = 1'b0;
    side = SIDE_X;
    if (can_x) begin
      base = cx * cq;
      sx = root64((len2 << 32) / dx2);
      lx = (dx < 0 ? px - base : base + cq - px) * sx;
    end
    if (can_y) begin
      base = cy * cq;
      sy = root64((len2 << 32) / dy2);
      ly = (dy < 0 ? py - base : base + cq - py) * sy;
    end
    lim = longint'(cur_limit) << 16;
    while (!hit && total < lim && (can_x || can_y)) begin
      // tie goes to y
      if (can_x && (!can_y || lx < ly)) begin
        cx += (dx < 0) ? -1 : 1;
        total = lx;
        lx += sx * cq;
        side = SIDE_X;
      end else begin
        cy += (dy < 0) ? -1 : 1;
        total = ly;
        ly += sy * cq;
        side = SIDE_Y;
      end
      if (cx >= 0 && cy >= 0 && cx < w && cy < h)
        if (wall_bits[cy * w + cx]) hit = 1'b1;
    end
    ray_dist = total >> 16;
    if (ray_dist > 64'hFFFFFF) ray_dist = 64'hFFFFFF;
    res.hit = hit;
    res.hit_side = side;
    res.ray_distance = ray_dist[23:0];
    res.hit_x = ray_point(t.pos_x, dx, ray_dist);
    res.hit_y = ray_point(t.pos_y, dy, ray_dist);
    return res;
  endfunction

  // driver: present items at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || took) begin
      if (pending_q.size() > (took ? 1 : 0) && $urandom_range(99) >= send_idle) begin
        ray_req_t t;
        t = pending_q[took ? 1 : 0];
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= t.kind;
        in_ch.cell_index <= t.cell_index;
        in_ch.wall       <= t.wall;
        in_ch.pos_x      <= t.pos_x;
        in_ch.pos_y      <= t.pos_y;
        in_ch.dir_x      <= t.dir_x;
        in_ch.dir_y      <= t.dir_y;
      end else begin
        in_ch.valid <= 1'b0;
      end
      if (took) void'(pending_q.pop_front());
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.cell_index = '0;
    in_ch.wall = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.dir_x = '0;
    in_ch.dir_y = '0;
    out_ch.ready = 1'b0;
  end

  // receiver ready, with one long hold-off
  int hold_cnt = 0;
  always @(negedge clk) begin
    if (long_hold && hold_cnt < 3000) begin
      hold_cnt <= hold_cnt + 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor: sample transfers at the rising edge
  always @(posedge clk) begin
    took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      ray_req_t t;
      t = pending_q[0];
      if (t.kind == KIND_LOAD) begin
        wall_bits[t.cell_index] = t.wall;
        n_loads++;
      end else begin
        cast_q.push_back(trace_ray(t));
        n_casts++;
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cast_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b dist=%h", $time, out_ch.hit,
                 out_ch.ray_distance);
        errors++;
      end else begin
        ray_res_t e;
        e = cast_q.pop_front();
        if (e.hit) n_hits++;
        if (out_ch.hit !== e.hit || out_ch.hit_side !== e.hit_side ||
            out_ch.ray_distance !== e.ray_distance || out_ch.hit_x !== e.hit_x ||
            out_ch.hit_y !== e.hit_y) begin
          $display("%0t: mismatch exp hit=%0b side=%0b dist=%h x=%h y=%h", $time,
                   e.hit, e.hit_side, e.ray_distance, e.hit_x, e.hit_y);
          $display("%0t:          got hit=%0b side=%0b dist=%h x=%h y=%h", $time,
                   out_ch.hit, out_ch.hit_side, out_ch.ray_distance, out_ch.hit_x,
                   out_ch.hit_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", cast_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_load(int idx, bit w);
    ray_req_t t;
    t = '{KIND_LOAD, idx[11:0], w, 24'($urandom), 24'($urandom), 16'($urandom),
          16'($urandom)};
    pending_q.push_back(t);
  endtask

  task automatic add_cast(logic [23:0] px, logic [23:0] py, logic [15:0] dx,
                          logic [15:0] dy);
    ray_req_t t;
    t = '{KIND_CAST, 12'($urandom), 1'($urandom), px, py, dx, dy};
    pending_q.push_back(t);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || cast_q.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(int w, int h, int cs, int lim);
    logic [CFG_DW-1:0] vals [4];
    cfg_idx_t idx [4];
    vals = '{CFG_DW'(w), CFG_DW'(h), CFG_DW'(cs), CFG_DW'(lim)};
    idx = '{CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_CELL_SIZE, CFG_MAX_RAY};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_width = 7'(w);
    cur_height = 7'(h);
    cur_cell = 8'(cs);
    cur_limit = 24'(lim);
  endtask

  // write every in-use cell so that no walk reads an unwritten one
  task automatic fill_map();
    int w, h;
    w = (cur_width == 0) ? 1 : (cur_width > SIDE_MAX ? SIDE_MAX : cur_width);
    h = (cur_height == 0) ? 1 : (cur_height > SIDE_MAX ? SIDE_MAX : cur_height);
    for (int i = 0; i < w * h; i++) add_load(i, $urandom_range(99) < 30);
  endtask

  task automatic add_random(int n, bit casts_only);
    int span;
    logic [23:0] px, py;
    logic [15:0] dx, dy;
    span = ((cur_cell == 0) ? 1 : cur_cell) * 256 * 66;
    for (int i = 0; i < n; i++) begin
      if (!casts_only && $urandom_range(9) < 2) begin
        add_load(int'($urandom_range(4095)), 1'($urandom_range(1)));
      end else begin
        if ($urandom_range(9) < 7) begin
          px = 24'($urandom_range(span));
          py = 24'($urandom_range(span));
        end else begin
          px = 24'($urandom);
          py = 24'($urandom);
        end
        dx = 16'($urandom);
        dy = 16'($urandom);
        case ($urandom_range(9))
          0: dx = '0;
          1: dy = '0;
          2: begin
            dx = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            dy = 16'($urandom_range(4000) - 2000);
          end
          default: ;
        endcase
        add_cast(px, py, dx, dy);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_regs(8, 8, 64, 64 * 256 * 30);
    fill_map();
    add_load(4095, 1'b1);
    add_cast(24'h050000, 24'h030000, 16'sd0, 16'sd0);
    add_cast(24'h050000, 24'h030000, 16'sd16384, 16'sd0);
    add_cast(24'h050000, 24'h030000, -16'sd16384, 16'sd0);
    add_cast(24'h050000, 24'h030000, 16'sd0, 16'sd16384);
    add_cast(24'h050000, 24'h030000, 16'sd0, -16'sd16384);
    add_cast(24'h008000, 24'h008000, 16'sd11585, 16'sd11585);
    add_cast(24'h010000, 24'h010000, -16'sd11585, 16'sd11585);
    add_cast(24'h048123, 24'h02ABCD, 16'sd32767, -16'sd32768);
    add_cast(24'h048123, 24'h02ABCD, -16'sd32768, 16'sd32767);
    add_cast(24'h000000, 24'h000000, -16'sd16384, -16'sd16384);
    add_cast(24'hFFFFFF, 24'hFFFFFF, 16'sd16384, 16'sd16384);
    add_cast(24'hFFFFFF, 24'hFFFFFF, -16'sd16384, -16'sd1);
    add_cast(24'h000000, 24'hFFFFFF, 16'sd1, -16'sd32768);
    add_random(40, 1'b0);
    wait_drained();

    send_idle = 87;
    set_regs(64, 1, 1, 256 * 60);
    fill_map();
    add_random(30, 1'b0);
    wait_drained();

    // long walks with the full limit; hold results back while casts queue up
    send_idle = 0;
    recv_stall = 87;
    set_regs(1, 64, 255, 24'hFFFFFF);
    fill_map();
    add_random(12, 1'b1);
    long_hold = 1'b1;
    wait_drained();

    // out-of-range registers and a zero limit
    send_idle = 18;
    recv_stall = 18;
    set_regs(0, 127, 0, 0);
    fill_map();
    add_random(20, 1'b0);
    wait_drained();

    set_regs(5, 7, 3, 3 * 256 * 50);
    fill_map();
    add_random(30, 1'b0);
    send_idle = 0;
    recv_stall = 0;
    add_random(30, 1'b0);
    wait_drained();

    repeat (END_WAIT) @(posedge clk);
    $display("covered %0d map writes and %0d casts (%0d hits) over five register sets",
             n_loads, n_casts, n_hits);
    if (errors == 0 && cast_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : tb_top
